// ===== hw/rtl/qdot_pkg.sv =====
`default_nettype none
package qdot_pkg;

  // Four lanes of eight elements each make up one 32-element block.
  localparam int LANES      = 4;
  localparam int LANE_ELEMS = 8;
  localparam int NIB_W      = 4;
  localparam int ACT_W      = 8;
  localparam int PROD_W     = NIB_W + ACT_W;   // one 4x8 signed product
  localparam int LANE_W     = 15;              // sum of eight products
  localparam int DOT_W      = 17;              // block dot, -32512..32768
  localparam int SCALE_W    = 24;
  localparam int SPROD_W    = 2 * SCALE_W;     // weight_scale * act_scale
  localparam int SPLIT      = SPROD_W / 2;     // scale product cut point
  localparam int PLO_W      = DOT_W + SPLIT + 1;
  localparam int PHI_W      = DOT_W + SPROD_W - SPLIT;
  localparam int ACC_W      = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Per-stage tag that travels alongside the datapath.
  typedef struct packed {
    logic valid;
    logic last;
  } qdot_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qdot_lane.sv =====
`default_nettype none
module qdot_lane (
  input  logic                                                clk,
  input  logic                                                adv,
  input  logic [qdot_pkg::LANE_ELEMS*qdot_pkg::NIB_W-1:0]     nibs,
  input  logic [qdot_pkg::LANE_ELEMS*qdot_pkg::ACT_W-1:0]     acts,
  output logic [qdot_pkg::LANE_W-1:0]                         lane_sum
);
  import qdot_pkg::*;

  logic signed [NIB_W-1:0]  w   [LANE_ELEMS];
  logic signed [ACT_W-1:0]  a   [LANE_ELEMS];
  logic signed [PROD_W-1:0] prod[LANE_ELEMS];
  logic signed [LANE_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANE_ELEMS; i++) begin
      // nibble minus 8 is the nibble with its top bit flipped, read as signed
      w[i]    = $signed({~nibs[NIB_W*i + NIB_W-1], nibs[NIB_W*i +: NIB_W-1]});
      a[i]    = $signed(acts[ACT_W*i +: ACT_W]);
      prod[i] = w[i] * a[i];
      sum     = sum + LANE_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_sum <= sum;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qdot_merge.sv =====
`default_nettype none
module qdot_merge (
  input  logic                                           clk,
  input  logic                                           adv,
  input  logic [qdot_pkg::LANES-1:0][qdot_pkg::LANE_W-1:0] lane_sums,
  input  logic signed [qdot_pkg::SPROD_W-1:0]            sprod,
  output logic signed [qdot_pkg::ACC_W-1:0]              term
);
  import qdot_pkg::*;

  logic signed [DOT_W-1:0]   dot_next;
  logic signed [DOT_W-1:0]   dot;
  logic signed [SPROD_W-1:0] sprod_d;
  logic signed [PLO_W-1:0]   p_lo;
  logic signed [PHI_W-1:0]   p_hi;

  always_comb begin
    dot_next = '0;
    for (int i = 0; i < LANES; i++) begin
      dot_next = dot_next + DOT_W'($signed(lane_sums[i]));
    end
  end

  // Merge lanes, split the 48-bit scale product into two partial products and recombine them into the term.
  always_ff @(posedge clk) begin
    if (adv) begin
      dot     <= dot_next;
      sprod_d <= sprod;
      p_lo    <= dot * $signed({1'b0, sprod_d[SPLIT-1:0]});
      p_hi    <= dot * $signed(sprod_d[SPROD_W-1:SPLIT]);
      term    <= (ACC_W'(p_hi) <<< SPLIT) + ACC_W'(p_lo);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qdot_acc.sv =====
`default_nettype none
module qdot_acc (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  qdot_pkg::qdot_tag_t                tag,
  input  logic signed [qdot_pkg::ACC_W-1:0]  term,
  output logic                               out_valid,
  output logic signed [qdot_pkg::ACC_W-1:0]  row_sum,
  output logic                               saturated
);
  import qdot_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic                    sticky;
  logic signed [ACC_W:0]   wide_sum;
  logic                    ovf;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    wide_sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    ovf      = wide_sum[ACC_W] != wide_sum[ACC_W-1];
    if (!ovf) begin
      acc_next = wide_sum[ACC_W-1:0];
    end else if (wide_sum[ACC_W]) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sticky    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tag.valid && tag.last;
      if (tag.valid) begin
        if (tag.last) begin
          acc    <= '0;
          sticky <= 1'b0;
        end else begin
          acc    <= acc_next;
          sticky <= sticky | ovf;
        end
      end
    end
  end

  // Result register: load on the row's final block.
  always_ff @(posedge clk) begin
    if (adv && tag.valid && tag.last) begin
      row_sum   <= acc_next;
      saturated <= sticky | ovf;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/q4_q8_block_dot_accumulator_top.sv =====
// A row's sum passes the lane, dot, partial-product, term and result registers.
// Throughput: one block per cycle unless stalled; four lanes of eight MACs,
// a merge adder, a split 17x48 scale multiply and a 64-bit saturating add.
// The whole pipeline holds while a result waits to be taken.
// Reset (rst, synchronous): clears the accumulator, sticky flag and all valids.
`default_nettype none
module q4_q8_block_dot_accumulator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [63:0]                        weight_bytes_low,
  input  logic [63:0]                        weight_bytes_high,
  input  logic [63:0]                        act_group_0,
  input  logic [63:0]                        act_group_1,
  input  logic [63:0]                        act_group_2,
  input  logic [63:0]                        act_group_3,
  input  logic signed [qdot_pkg::SCALE_W-1:0] weight_scale,
  input  logic signed [qdot_pkg::SCALE_W-1:0] act_scale,
  input  logic                               last_block,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qdot_pkg::ACC_W-1:0]  row_sum,
  output logic                               saturated
);
  import qdot_pkg::*;

  logic                                     adv;
  logic [LANES-1:0][LANE_ELEMS*NIB_W-1:0]   lane_nibs;
  logic [LANES-1:0][LANE_ELEMS*ACT_W-1:0]   lane_acts;
  logic [LANES-1:0][LANE_W-1:0]             lane_sums;
  logic signed [SPROD_W-1:0]                sprod;
  logic signed [ACC_W-1:0]                  term;
  qdot_tag_t                                tag1, tag2, tag3, tag4;

  // The whole pipeline moves whenever the result register is free or draining.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Lanes 0/1 take low nibbles of bytes 0-7/8-15, lanes 2/3 the high nibbles.
  always_comb begin
    for (int j = 0; j < LANE_ELEMS; j++) begin
      lane_nibs[0][NIB_W*j +: NIB_W] = weight_bytes_low [8*j +: NIB_W];
      lane_nibs[1][NIB_W*j +: NIB_W] = weight_bytes_high[8*j +: NIB_W];
      lane_nibs[2][NIB_W*j +: NIB_W] = weight_bytes_low [8*j + NIB_W +: NIB_W];
      lane_nibs[3][NIB_W*j +: NIB_W] = weight_bytes_high[8*j + NIB_W +: NIB_W];
    end
    lane_acts[0] = act_group_0;
    lane_acts[1] = act_group_1;
    lane_acts[2] = act_group_2;
    lane_acts[3] = act_group_3;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    qdot_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .nibs     (lane_nibs[g]),
      .acts     (lane_acts[g]),
      .lane_sum (lane_sums[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sprod <= weight_scale * act_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else if (adv) begin
      tag1 <= '{valid: in_valid, last: last_block};
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  qdot_merge u_merge (
    .clk       (clk),
    .adv       (adv),
    .lane_sums (lane_sums),
    .sprod     (sprod),
    .term      (term)
  );

  qdot_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag       (tag4),
    .term      (term),
    .out_valid (out_valid),
    .row_sum   (row_sum),
    .saturated (saturated)
  );

  // Stall only while a result sits in the output register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A new result must come from a final block at the pipeline tail.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(tag4.valid && tag4.last))
    else $error("result without a final block");

  // A final block that moves out of the tail must produce a result.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(adv && tag4.valid && tag4.last) |-> out_valid)
    else $error("final block dropped");

  // A held pipeline keeps its tail tag.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(adv) |-> $stable(tag4))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
